[hdl/priority_periodic_task_scheduler_defines.svh]
// Assertion macros shared by the scheduler checker.
// No dependencies; include guarded.
`ifndef PRIORITY_PERIODIC_TASK_SCHEDULER_DEFINES_SVH
`define PRIORITY_PERIODIC_TASK_SCHEDULER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define PPTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that must also hold across reset.
`define PPTS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/ppts_pkg.sv]
// Shared types, codes and helpers of the periodic task scheduler.
// Used by the controller, the datapath, the top level and the checker.
package ppts_pkg;

   localparam int MAX_SLOTS = 16;
   localparam int MAX_RES   = 16;
   localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
   localparam int RES_W     = $clog2(MAX_RES + 1);
   localparam logic [31:0] LONG_RUN_RESET = 32'd3000;

   typedef enum logic [3:0] {
      FN_ADD      = 4'd0,
      FN_REMOVE   = 4'd1,
      FN_ENABLE   = 4'd2,
      FN_DISABLE  = 4'd3,
      FN_SET_IVAL = 4'd4,
      FN_TICK     = 4'd5,
      FN_REPORT   = 4'd6,
      FN_STOP     = 4'd7,
      FN_RESTART  = 4'd8,
      FN_PAUSE    = 4'd9,
      FN_RESUME   = 4'd10,
      FN_CLEAR    = 4'd11,
      FN_QUERY    = 4'd12
   } func_type;

   typedef enum logic [2:0] {
      STS_OK        = 3'd0,
      STS_FULL      = 3'd1,
      STS_DUP       = 3'd2,
      STS_NOT_FOUND = 3'd3,
      STS_PAUSED    = 3'd4,
      STS_NONE_DUE  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      WARN_NONE  = 2'd0,
      WARN_CLOSE = 2'd1,
      WARN_LONG  = 2'd2
   } warn_type;

   localparam logic [1:0] PRIO_NORMAL = 2'd1;

   typedef struct packed {
      logic [7:0]  key;
      logic [1:0]  prio;
      logic [31:0] ival;
      logic [31:0] last_run;
      logic        en;
      logic [31:0] created;
      logic [31:0] run_cnt;
      logic [31:0] last_exec;
      logic [31:0] max_exec;
      logic [31:0] total_exec;
   } slot_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  key;
      logic        last;
      logic [1:0]  prio;
      logic        en;
      logic [31:0] run_cnt;
      logic [31:0] last_exec;
      logic [31:0] max_exec;
      logic [31:0] total_exec;
      logic [31:0] uptime;
      warn_type    warn;
   } result_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic exec;
      logic scan_init;
      logic scan_step;
      logic fin;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_tick;
      logic running;
      logic scan_done;
      logic scan_due;
      logic pend_valid;
      logic out_free;
   } stat_type;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 176;

   function automatic result_type slot_result(slot_type row, logic [31:0] now);
      result_type r;
      r.status     = STS_OK;
      r.key        = row.key;
      r.last       = 1'b0;
      r.prio       = row.prio;
      r.en         = row.en;
      r.run_cnt    = row.run_cnt;
      r.last_exec  = row.last_exec;
      r.max_exec   = row.max_exec;
      r.total_exec = row.total_exec;
      r.uptime     = now - row.created;
      r.warn       = WARN_NONE;
      return r;
   endfunction

   function automatic result_type empty_result(status_type st, logic [7:0] key,
                                               logic last);
      result_type r;
      r        = '0;
      r.status = st;
      r.key    = key;
      r.last   = last;
      return r;
   endfunction

endpackage

[hdl/ppts_ctrl.sv]
// Sequencing state machine of the scheduler.
// Depends on ppts_pkg for the command and status structs.
module ppts_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  ppts_pkg::stat_type stat,
   output ppts_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SCAN, ST_FIN} state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.is_tick && stat.running) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end else if (stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // A due slot may only be taken once the previous one can move on.
            if (stat.scan_done) begin
               state_in = ST_FIN;
            end else if (!stat.scan_due || !stat.pend_valid || stat.out_free) begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_FIN: begin
            if (stat.out_free) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/ppts_dpath.sv]
// Slot table, item latch, tick scan, result registers and config register.
// Depends on ppts_pkg; driven by commands from ppts_ctrl.
module ppts_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  ppts_pkg::cmd_type                   cmd,
   output ppts_pkg::stat_type                  stat,
   input  logic [3:0]                          req_tuser,
   input  logic [ppts_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ppts_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [2:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [2:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   ppts_pkg::slot_type rows_ff [ppts_pkg::MAX_SLOTS];
   ppts_pkg::slot_type rows_in [ppts_pkg::MAX_SLOTS];

   logic [3:0]  func_ff;
   logic [7:0]  key_ff;
   logic [31:0] ival_ff;
   logic [1:0]  prio_ff;
   logic        en_ff;
   logic [31:0] now_ff;
   logic        severe_ff;
   logic [31:0] dur_ff;

   logic [ppts_pkg::CNT_W-1:0] used_ff, used_in;
   logic                       running_ff, running_in;
   logic [31:0]                limit_ff;
   logic [ppts_pkg::CNT_W-1:0] idx_ff;
   logic [ppts_pkg::RES_W-1:0] cnt_ff;
   ppts_pkg::result_type       pend_ff;
   logic                       pend_v_ff;
   ppts_pkg::result_type       out_ff;
   logic                       out_v_ff;

   logic                       hit;
   logic [ppts_pkg::IDX_W-1:0] sidx;
   logic [ppts_pkg::CNT_W-1:0] pos;
   ppts_pkg::slot_type         sel_row, upd_row, new_row, scan_row;
   ppts_pkg::result_type       exec_res;
   ppts_pkg::result_type       fin_res;
   logic [34:0]                dur_x5;
   logic                       scan_due;
   logic                       out_free;

   // Key lookup over the used part of the table; lowest index wins.
   always_comb begin
      hit  = 1'b0;
      sidx = '0;
      for (int i = ppts_pkg::MAX_SLOTS - 1; i >= 0; i--) begin
         if ((ppts_pkg::CNT_W'(i) < used_ff) && (rows_ff[i].key == key_ff)) begin
            hit  = 1'b1;
            sidx = ppts_pkg::IDX_W'(i);
         end
      end
   end

   // The table is sorted by priority, so the insert point is the first slot
   // whose priority is lower than the new one.
   always_comb begin
      pos = used_ff;
      for (int i = ppts_pkg::MAX_SLOTS - 1; i >= 0; i--) begin
         if (!((ppts_pkg::CNT_W'(i) < used_ff) && (rows_ff[i].prio >= prio_ff))) begin
            pos = ppts_pkg::CNT_W'(i);
         end
      end
   end

   assign sel_row  = rows_ff[sidx];
   assign scan_row = rows_ff[idx_ff[ppts_pkg::IDX_W-1:0]];
   assign dur_x5   = {1'b0, dur_ff, 2'b00} + {3'b000, dur_ff};
   assign out_free = !out_v_ff || rsp_tready;

   assign scan_due = scan_row.en
                     && !(severe_ff && (scan_row.prio <= ppts_pkg::PRIO_NORMAL))
                     && ((now_ff - scan_row.last_run) >= scan_row.ival);

   always_comb begin
      new_row            = '0;
      new_row.key        = key_ff;
      new_row.prio       = prio_ff;
      new_row.ival       = ival_ff;
      new_row.en         = en_ff;
      new_row.created    = now_ff;
   end

   always_comb begin
      fin_res      = pend_ff;
      fin_res.last = 1'b1;
   end

   always_comb begin
      upd_row = sel_row;
      case (ppts_pkg::func_type'(func_ff))
         ppts_pkg::FN_ENABLE: begin
            if (!sel_row.en) begin
               upd_row.en       = 1'b1;
               upd_row.last_run = now_ff;
            end
         end
         ppts_pkg::FN_DISABLE:  upd_row.en   = 1'b0;
         ppts_pkg::FN_SET_IVAL: upd_row.ival = ival_ff;
         ppts_pkg::FN_REPORT: begin
            upd_row.last_exec  = dur_ff;
            upd_row.run_cnt    = sel_row.run_cnt + 32'd1;
            upd_row.total_exec = sel_row.total_exec + dur_ff;
            if (dur_ff > sel_row.max_exec) begin
               upd_row.max_exec = dur_ff;
            end
         end
         default: upd_row = sel_row;
      endcase
   end

   // Next table, counters and result for the operations done in one step.
   always_comb begin
      rows_in    = rows_ff;
      used_in    = used_ff;
      running_in = running_ff;
      exec_res   = ppts_pkg::empty_result(ppts_pkg::STS_OK, key_ff, 1'b0);
      if (cmd.exec) begin
         case (ppts_pkg::func_type'(func_ff))
            ppts_pkg::FN_ADD: begin
               if (used_ff >= ppts_pkg::CNT_W'(ppts_pkg::MAX_SLOTS)) begin
                  exec_res = ppts_pkg::empty_result(ppts_pkg::STS_FULL, key_ff, 1'b0);
               end else if (hit) begin
                  exec_res = ppts_pkg::empty_result(ppts_pkg::STS_DUP, key_ff, 1'b0);
               end else begin
                  for (int i = 0; i < ppts_pkg::MAX_SLOTS; i++) begin
                     if (ppts_pkg::CNT_W'(i) == pos) begin
                        rows_in[i] = new_row;
                     end else if ((ppts_pkg::CNT_W'(i) > pos)
                                  && (ppts_pkg::CNT_W'(i) <= used_ff)) begin
                        rows_in[i] = rows_ff[(i == 0) ? 0 : i - 1];
                     end
                  end
                  used_in  = used_ff + 1'b1;
                  exec_res = ppts_pkg::slot_result(new_row, now_ff);
               end
            end
            ppts_pkg::FN_REMOVE: begin
               if (!hit) begin
                  exec_res = ppts_pkg::empty_result(ppts_pkg::STS_NOT_FOUND, key_ff,
                                                    1'b0);
               end else begin
                  exec_res = ppts_pkg::slot_result(sel_row, now_ff);
                  for (int i = 0; i < ppts_pkg::MAX_SLOTS; i++) begin
                     if ((ppts_pkg::IDX_W'(i) >= sidx) && (i < ppts_pkg::MAX_SLOTS - 1)) begin
                        rows_in[i] = rows_ff[(i == ppts_pkg::MAX_SLOTS - 1) ? i : i + 1];
                     end
                  end
                  used_in = used_ff - 1'b1;
               end
            end
            ppts_pkg::FN_ENABLE, ppts_pkg::FN_DISABLE, ppts_pkg::FN_SET_IVAL,
            ppts_pkg::FN_REPORT: begin
               if (!hit) begin
                  exec_res = ppts_pkg::empty_result(ppts_pkg::STS_NOT_FOUND, key_ff,
                                                    1'b0);
               end else begin
                  rows_in[sidx] = upd_row;
                  exec_res      = ppts_pkg::slot_result(upd_row, now_ff);
                  if (ppts_pkg::func_type'(func_ff) == ppts_pkg::FN_REPORT) begin
                     if (dur_ff > limit_ff) begin
                        exec_res.warn = ppts_pkg::WARN_LONG;
                     end else if (dur_x5 > {1'b0, sel_row.ival, 2'b00}) begin
                        exec_res.warn = ppts_pkg::WARN_CLOSE;
                     end
                  end
               end
            end
            ppts_pkg::FN_TICK: begin
               exec_res = ppts_pkg::empty_result(ppts_pkg::STS_PAUSED, key_ff, 1'b0);
            end
            ppts_pkg::FN_STOP: begin
               if (running_ff) begin
                  for (int i = 0; i < ppts_pkg::MAX_SLOTS; i++) begin
                     rows_in[i].en = 1'b0;
                  end
                  running_in = 1'b0;
               end
               exec_res = ppts_pkg::empty_result(ppts_pkg::STS_OK, 8'd0, 1'b1);
            end
            ppts_pkg::FN_RESTART: begin
               for (int i = 0; i < ppts_pkg::MAX_SLOTS; i++) begin
                  rows_in[i].en       = 1'b1;
                  rows_in[i].last_run = now_ff;
               end
               running_in = 1'b1;
               exec_res   = ppts_pkg::empty_result(ppts_pkg::STS_OK, 8'd0, 1'b1);
            end
            ppts_pkg::FN_PAUSE: begin
               running_in = 1'b0;
               exec_res   = ppts_pkg::empty_result(ppts_pkg::STS_OK, 8'd0, 1'b1);
            end
            ppts_pkg::FN_RESUME: begin
               running_in = 1'b1;
               exec_res   = ppts_pkg::empty_result(ppts_pkg::STS_OK, 8'd0, 1'b1);
            end
            ppts_pkg::FN_CLEAR: begin
               used_in  = '0;
               exec_res = ppts_pkg::empty_result(ppts_pkg::STS_OK, 8'd0, 1'b1);
            end
            ppts_pkg::FN_QUERY: begin
               if (!hit) begin
                  exec_res = ppts_pkg::empty_result(ppts_pkg::STS_NOT_FOUND, key_ff,
                                                    1'b1);
                  exec_res.prio = ppts_pkg::PRIO_NORMAL;
               end else begin
                  exec_res      = ppts_pkg::slot_result(sel_row, now_ff);
                  exec_res.last = 1'b1;
               end
            end
            default: begin
               exec_res = ppts_pkg::empty_result(ppts_pkg::STS_OK, 8'd0, 1'b1);
            end
         endcase
      end else if (cmd.scan_step && scan_due) begin
         rows_in[idx_ff[ppts_pkg::IDX_W-1:0]].last_run = now_ff;
      end
   end

   always_ff @(posedge clock) begin
      rows_ff <= rows_in;
      if (cmd.load) begin
         func_ff   <= req_tuser;
         key_ff    <= req_tdata[7:0];
         ival_ff   <= req_tdata[39:8];
         prio_ff   <= req_tdata[41:40];
         en_ff     <= req_tdata[42];
         now_ff    <= req_tdata[74:43];
         severe_ff <= req_tdata[75];
         dur_ff    <= req_tdata[107:76];
      end
      if (cmd.scan_step && scan_due) begin
         pend_ff <= ppts_pkg::slot_result(rows_in[idx_ff[ppts_pkg::IDX_W-1:0]], now_ff);
      end
      if (cmd.exec) begin
         out_ff <= exec_res;
      end else if (cmd.scan_step && scan_due && pend_v_ff) begin
         out_ff <= pend_ff;
      end else if (cmd.fin) begin
         if (pend_v_ff) begin
            out_ff <= fin_res;
         end else begin
            out_ff <= ppts_pkg::empty_result(ppts_pkg::STS_NONE_DUE, key_ff, 1'b0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         running_ff <= 1'b1;
         limit_ff   <= ppts_pkg::LONG_RUN_RESET;
         idx_ff     <= '0;
         cnt_ff     <= '0;
         pend_v_ff  <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         used_ff    <= used_in;
         running_ff <= running_in;
         if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
            limit_ff <= csr_pwdata;
         end
         if (cmd.scan_init) begin
            idx_ff    <= '0;
            cnt_ff    <= '0;
            pend_v_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            idx_ff <= idx_ff + 1'b1;
            if (scan_due) begin
               cnt_ff    <= cnt_ff + 1'b1;
               pend_v_ff <= 1'b1;
            end
         end else if (cmd.fin) begin
            pend_v_ff <= 1'b0;
         end
         if (cmd.exec || cmd.fin || (cmd.scan_step && scan_due && pend_v_ff)) begin
            out_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   assign stat.is_tick    = (ppts_pkg::func_type'(func_ff) == ppts_pkg::FN_TICK);
   assign stat.running    = running_ff;
   assign stat.scan_done  = (idx_ff >= used_ff)
                            || (cnt_ff >= ppts_pkg::RES_W'(ppts_pkg::MAX_RES));
   assign stat.scan_due   = scan_due;
   assign stat.pend_valid = pend_v_ff;
   assign stat.out_free   = out_free;

   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {3'b000, out_ff.warn, out_ff.uptime, out_ff.total_exec,
                        out_ff.max_exec, out_ff.last_exec, out_ff.run_cnt,
                        out_ff.en, out_ff.prio, out_ff.key};

   assign csr_prdata = csr_paddr[2] ? 32'd0 : limit_ff;
   assign csr_pready = 1'b1;

endmodule

[hdl/priority_periodic_task_scheduler.sv]
// Channel  | Dir | Handshake          | Contents
// req      | in  | req_tvalid/tready  | tuser func, tdata operands
// rsp      | out | rsp_tvalid/tready  | tuser status, tdata slot fields, tlast
// csr      | in  | psel/penable       | long_run_limit_ms at addresses 0-3
//
// One item is taken at a time: latched, then executed once the result register is
// free, then emitted. A tick walks the table one slot per cycle, stalling on a due
// slot while an earlier due slot is pending and rsp_tready holds the result register.
// Reset is synchronous; the slot table needs no clearing pass.
// Top level; depends on ppts_pkg, ppts_ctrl and ppts_dpath.
module priority_periodic_task_scheduler (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // func[3:0]
   input  logic [3:0]                      req_tuser,
   // task_key, interval_ms, priority_in, start_enabled, now_ms, memory_severe,
   // duration_ms, zero fill
   input  logic [ppts_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[2:0]
   output logic [2:0]                      rsp_tuser,
   // due_key, priority_out, enabled_out, run_count, last_exec_ms, max_exec_ms,
   // total_exec_ms, uptime_ms, warning, zero fill
   output logic [ppts_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [2:0]                      csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   ppts_pkg::cmd_type  cmd;
   ppts_pkg::stat_type stat;

   ppts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ppts_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

endmodule

[hdl/ppts_checker.sv]
// Port-level checks of the scheduler, bound to the top level.
// Depends on ppts_pkg and priority_periodic_task_scheduler_defines.svh.
`include "priority_periodic_task_scheduler_defines.svh"

module ppts_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [2:0]                      rsp_tuser,
   input logic [ppts_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   // A stalled result keeps its place.
   `PPTS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped while stalled")

   // Reset leaves no result pending.
   `PPTS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result pending after reset")

   // An accepted item keeps the input closed for the next cycle.
   `PPTS_ASSERT(a_one_item, clock, reset, req_tvalid && req_tready |=> !req_tready, "second item taken at once")

   // Failed or empty results carry no slot statistics.
   `PPTS_ASSERT(a_no_stats, clock, reset, rsp_tvalid && (rsp_tuser != ppts_pkg::STS_OK) |-> (rsp_tdata[170:11] == '0), "statistics on a failed result")

   // Paused and nothing-due results never close a tick run.
   `PPTS_ASSERT(a_tick_last, clock, reset, rsp_tvalid && ((rsp_tuser == ppts_pkg::STS_PAUSED) || (rsp_tuser == ppts_pkg::STS_NONE_DUE)) |-> !rsp_tlast, "tlast on empty tick")

endmodule

bind priority_periodic_task_scheduler ppts_checker u_ppts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

[tb/tb_top.sv]
// Self-checking testbench for priority_periodic_task_scheduler: a queue-fed
// driver and a result monitor check every result against an in-bench predictor.
// Depends on ppts_pkg and the scheduler RTL.
module tb_top;

   typedef struct {
      logic [3:0]  func;
      logic [7:0]  key;
      logic [31:0] ival;
      logic [1:0]  prio;
      logic        en;
      logic [31:0] now;
      logic        severe;
      logic [31:0] dur;
   } sched_cmd_type;

   typedef struct {
      logic [7:0]  key;
      logic [1:0]  prio;
      logic [31:0] ival;
      logic [31:0] last_run;
      logic        en;
      logic [31:0] created;
      logic [31:0] runs;
      logic [31:0] last_exec;
      logic [31:0] max_exec;
      logic [31:0] total_exec;
   } task_entry_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        last;
      logic [2:0]  fill;
      logic [1:0]  warn;
      logic [31:0] uptime;
      logic [31:0] total_exec;
      logic [31:0] max_exec;
      logic [31:0] last_exec;
      logic [31:0] runs;
      logic        en;
      logic [1:0]  prio;
      logic [7:0]  key;
   } sched_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [3:0] req_tuser = '0;
   logic [ppts_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [2:0] rsp_tuser;
   logic [ppts_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   priority_periodic_task_scheduler dut (.*);

   // Predictor state.
   task_entry_type   tbl [ppts_pkg::MAX_SLOTS];
   int               used = 0;
   bit               running = 1'b1;
   logic [31:0]      long_limit = ppts_pkg::LONG_RUN_RESET;

   sched_cmd_type    pending_q [$];
   sched_result_type expected_q [$];
   sched_cmd_type    cur_cmd;
   int               send_gap = 0;
   int               recv_gap = 0;
   int               hold_cnt = 0;
   bit               held_once = 1'b0;
   int               accepted = 0;
   int               errors = 0;
   logic [31:0]      clk_ms = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic sched_result_type slot_view(int idx, logic [31:0] now);
      sched_result_type r;
      r = '0;
      r.key        = tbl[idx].key;
      r.prio       = tbl[idx].prio;
      r.en         = tbl[idx].en;
      r.runs       = tbl[idx].runs;
      r.last_exec  = tbl[idx].last_exec;
      r.max_exec   = tbl[idx].max_exec;
      r.total_exec = tbl[idx].total_exec;
      r.uptime     = now - tbl[idx].created;
      return r;
   endfunction

   function automatic sched_result_type no_slot(ppts_pkg::status_type st,
                                                logic [7:0] key);
      sched_result_type r;
      r = '0;
      r.status = st;
      r.key    = key;
      return r;
   endfunction

   task automatic schedule_step(input sched_cmd_type c);
      sched_result_type r;
      int hit, pos, n;
      logic [34:0] lhs, rhs;
      hit = -1;
      for (int i = 0; i < used; i++)
         if (hit < 0 && tbl[i].key == c.key) hit = i;
      r = no_slot(ppts_pkg::STS_OK, 8'd0);
      case (c.func)
         ppts_pkg::FN_ADD: begin
            if (used >= ppts_pkg::MAX_SLOTS) r = no_slot(ppts_pkg::STS_FULL, c.key);
            else if (hit >= 0) r = no_slot(ppts_pkg::STS_DUP, c.key);
            else begin
               pos = 0;
               while (pos < used && tbl[pos].prio >= c.prio) pos++;
               for (int i = used; i > pos; i--) tbl[i] = tbl[i-1];
               tbl[pos] = '{c.key, c.prio, c.ival, 32'd0, c.en, c.now,
                            32'd0, 32'd0, 32'd0, 32'd0};
               used++;
               r = slot_view(pos, c.now);
            end
         end
         ppts_pkg::FN_REMOVE: begin
            if (hit < 0) r = no_slot(ppts_pkg::STS_NOT_FOUND, c.key);
            else begin
               r = slot_view(hit, c.now);
               for (int i = hit; i + 1 < used; i++) tbl[i] = tbl[i+1];
               used--;
            end
         end
         ppts_pkg::FN_ENABLE, ppts_pkg::FN_DISABLE, ppts_pkg::FN_SET_IVAL,
         ppts_pkg::FN_REPORT: begin
            if (hit < 0) r = no_slot(ppts_pkg::STS_NOT_FOUND, c.key);
            else begin
               if (c.func == ppts_pkg::FN_ENABLE && !tbl[hit].en) begin
                  tbl[hit].en = 1'b1;
                  tbl[hit].last_run = c.now;
               end else if (c.func == ppts_pkg::FN_DISABLE) tbl[hit].en = 1'b0;
               else if (c.func == ppts_pkg::FN_SET_IVAL) tbl[hit].ival = c.ival;
               else if (c.func == ppts_pkg::FN_REPORT) begin
                  tbl[hit].last_exec = c.dur;
                  if (c.dur > tbl[hit].max_exec) tbl[hit].max_exec = c.dur;
                  tbl[hit].runs++;
                  tbl[hit].total_exec += c.dur;
               end
               r = slot_view(hit, c.now);
               if (c.func == ppts_pkg::FN_REPORT) begin
                  lhs = {3'b0, c.dur} * 35'd5;
                  rhs = {3'b0, tbl[hit].ival} * 35'd4;
                  if (c.dur > long_limit) r.warn = ppts_pkg::WARN_LONG;
                  else if (lhs > rhs) r.warn = ppts_pkg::WARN_CLOSE;
               end
            end
         end
         ppts_pkg::FN_TICK: begin
            if (!running) r = no_slot(ppts_pkg::STS_PAUSED, c.key);
            else begin
               n = 0;
               for (int i = 0; i < used && n < ppts_pkg::MAX_RES; i++) begin
                  if (tbl[i].en && !(c.severe && tbl[i].prio <= ppts_pkg::PRIO_NORMAL) &&
                      (c.now - tbl[i].last_run) >= tbl[i].ival) begin
                     tbl[i].last_run = c.now;
                     expected_q.push_back(slot_view(i, c.now));
                     n++;
                  end
               end
               // The final due slot carries last and is queued again below.
               if (n == 0) r = no_slot(ppts_pkg::STS_NONE_DUE, c.key);
               else begin
                  r = expected_q.pop_back();
                  r.last = 1'b1;
               end
            end
         end
         ppts_pkg::FN_STOP: begin
            if (running) begin
               for (int i = 0; i < used; i++) tbl[i].en = 1'b0;
               running = 1'b0;
            end
            r.last = 1'b1;
         end
         ppts_pkg::FN_RESTART: begin
            for (int i = 0; i < used; i++) begin
               tbl[i].en = 1'b1;
               tbl[i].last_run = c.now;
            end
            running = 1'b1;
            r.last = 1'b1;
         end
         ppts_pkg::FN_PAUSE: begin
            running = 1'b0;
            r.last = 1'b1;
         end
         ppts_pkg::FN_RESUME: begin
            running = 1'b1;
            r.last = 1'b1;
         end
         ppts_pkg::FN_CLEAR: begin
            used = 0;
            r.last = 1'b1;
         end
         ppts_pkg::FN_QUERY: begin
            if (hit < 0) begin
               r = no_slot(ppts_pkg::STS_NOT_FOUND, c.key);
               r.prio = ppts_pkg::PRIO_NORMAL;
            end else r = slot_view(hit, c.now);
            r.last = 1'b1;
         end
         default: r.last = 1'b1;
      endcase
      expected_q.push_back(r);
   endtask

   // Driver: one item in flight on the request channel at a time.
   always @(posedge clock) begin
      sched_cmd_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            schedule_step(cur_cmd);
            accepted <= accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               nxt = pending_q.pop_front();
               cur_cmd <= nxt;
               req_tuser <= nxt.func;
               req_tdata <= {4'd0, nxt.dur, nxt.severe, nxt.now, nxt.en, nxt.prio,
                             nxt.ival, nxt.key};
               req_tvalid <= 1'b1;
               send_gap <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off to back up the block.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else if (!held_once && accepted >= 120) begin
         held_once <= 1'b1;
         hold_cnt <= 400;
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_tvalid && rsp_tready) recv_gap <= pick_gap();
      end
   end

   // Monitor.
   always @(posedge clock) begin
      sched_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tlast, rsp_tdata};
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected %p actual %p", $time, want, got);
               errors++;
            end
         end
      end
   end

   task automatic csr_write(input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'd0;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      long_limit = value;
   endtask

   task automatic wait_idle();
      while (pending_q.size() > 0 || req_tvalid || expected_q.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic sched_cmd_type mk(logic [3:0] f, logic [7:0] k, logic [31:0] iv,
                                        logic [1:0] p, logic e, logic sv,
                                        logic [31:0] d);
      sched_cmd_type c;
      clk_ms += $urandom_range(1500);
      c = '{f, k, iv, p, e, clk_ms, sv, d};
      return c;
   endfunction

   function automatic sched_cmd_type rand_cmd();
      sched_cmd_type c;
      int r;
      logic [3:0] f;
      r = $urandom_range(99);
      if (r < 25) f = ppts_pkg::FN_ADD;
      else if (r < 45) f = ppts_pkg::FN_TICK;
      else if (r < 57) f = ppts_pkg::FN_REPORT;
      else if (r < 62) f = ppts_pkg::FN_REMOVE;
      else if (r < 67) f = ppts_pkg::FN_ENABLE;
      else if (r < 71) f = ppts_pkg::FN_DISABLE;
      else if (r < 75) f = ppts_pkg::FN_SET_IVAL;
      else if (r < 84) f = ppts_pkg::FN_QUERY;
      else if (r < 86) f = ppts_pkg::FN_STOP;
      else if (r < 89) f = ppts_pkg::FN_RESTART;
      else if (r < 91) f = ppts_pkg::FN_PAUSE;
      else if (r < 94) f = ppts_pkg::FN_RESUME;
      else if (r < 95) f = ppts_pkg::FN_CLEAR;
      else f = 4'($urandom_range(15, 13));
      c = mk(f, ($urandom_range(9) < 8) ? 8'($urandom_range(19)) : 8'($urandom),
             ($urandom_range(9) < 8) ? 32'($urandom_range(3000)) : 32'($urandom),
             2'($urandom), 1'($urandom), 1'($urandom),
             ($urandom_range(9) < 8) ? 32'($urandom_range(4000)) : 32'($urandom));
      if ($urandom_range(19) == 0) begin
         clk_ms = $urandom;
         c.now = clk_ms;
      end
      return c;
   endfunction

   initial begin
      logic [31:0] limits [4];
      limits = '{32'd0, 32'hFFFF_FFFF, 32'd0, ppts_pkg::LONG_RUN_RESET};
      limits[2] = $urandom;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // Directed: extremes, every operation and a paused tick.
      pending_q.push_back(mk(ppts_pkg::FN_ADD, 8'hFF, 32'd0, 2'd3, 1'b1, 1'b0, 32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_ADD, 8'h00, 32'hFFFF_FFFF, 2'd0, 1'b1, 1'b1,
                             32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_ADD, 8'hFF, 32'd5, 2'd1, 1'b0, 1'b0, 32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_ADD, 8'h01, 32'd100, 2'd3, 1'b0, 1'b0, 32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_TICK, 8'h00, 32'd0, 2'd0, 1'b0, 1'b1, 32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_ENABLE, 8'h01, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_ENABLE, 8'h01, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_REPORT, 8'h01, 32'd0, 2'd0, 1'b0, 1'b0, 32'd81));
      pending_q.push_back(mk(ppts_pkg::FN_REPORT, 8'h01, 32'd0, 2'd0, 1'b0, 1'b0, 32'd80));
      pending_q.push_back(mk(ppts_pkg::FN_REPORT, 8'hFF, 32'd0, 2'd0, 1'b0, 1'b0,
                             32'hFFFF_FFFF));
      pending_q.push_back(mk(ppts_pkg::FN_SET_IVAL, 8'h00, 32'd0, 2'd0, 1'b0, 1'b0,
                             32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_TICK, 8'h00, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_TICK, 8'h07, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_DISABLE, 8'hFF, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_QUERY, 8'h55, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_REMOVE, 8'h55, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_STOP, 8'h00, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_STOP, 8'h00, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_TICK, 8'h09, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_RESTART, 8'h00, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_PAUSE, 8'h00, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_RESUME, 8'h00, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
      pending_q.push_back(mk(4'd13, 8'h00, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_REMOVE, 8'hFF, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
      pending_q.push_back(mk(ppts_pkg::FN_CLEAR, 8'h00, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0));
      wait_idle();
      foreach (limits[p]) begin
         csr_write(limits[p]);
         for (int i = 0; i < 55; i++) pending_q.push_back(rand_cmd());
         wait_idle();
      end
      if (errors == 0 && expected_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("tb: failure");
      $finish;
   end

endmodule
